[hw/rtl/irppd_pkg.sv]
// ----------------------------------------------------------------------------
// irppd_pkg: shared definitions for the IR pulse-pair decoder
// Field widths, register indexes, reset values and the frame bit limit.
// ----------------------------------------------------------------------------
package irppd_pkg;

	localparam int unsigned MAX_BITS = 32;

	localparam int unsigned TIME_W  = 16;
	localparam int unsigned CODE_W  = 32;
	localparam int unsigned COUNT_W = 6;
	localparam int unsigned HALF_W  = 7;
	localparam int unsigned TOL_W   = 8;
	localparam int unsigned TICK_W  = 8;
	localparam int unsigned INDEX_W = 3;
	localparam int unsigned DATA_W  = 16;

	typedef enum logic [INDEX_W-1:0] {
		REG_ZERO_LOW  = 3'd0,
		REG_ZERO_HIGH = 3'd1,
		REG_ONE_LOW   = 3'd2,
		REG_ONE_HIGH  = 3'd3,
		REG_TOLERANCE = 3'd4,
		REG_US_TICK   = 3'd5
	} reg_index_t;

	localparam logic [TIME_W-1:0] ZERO_LOW_RST  = 16'd560;
	localparam logic [TIME_W-1:0] ZERO_HIGH_RST = 16'd560;
	localparam logic [TIME_W-1:0] ONE_LOW_RST   = 16'd560;
	localparam logic [TIME_W-1:0] ONE_HIGH_RST  = 16'd1690;
	localparam logic [TOL_W-1:0]  TOLERANCE_RST = 8'd51;
	localparam logic [TICK_W-1:0] US_TICK_RST   = 8'd1;

	// Margin = floor(ref * tolerance / 256).
	function automatic logic [TIME_W-1:0] margin_of(input logic [TIME_W-1:0] ref_w,
		input logic [TOL_W-1:0] tol);
		logic [TIME_W+TOL_W-1:0] prod;
		prod = ref_w * tol;
		return prod[TIME_W+TOL_W-1:TOL_W];
	endfunction

	// Strict window: ref - margin < w < ref + margin.
	function automatic logic in_window(input logic [TIME_W-1:0] w,
		input logic [TIME_W-1:0] ref_w, input logic [TIME_W-1:0] margin);
		logic [TIME_W:0] w_plus;
		logic [TIME_W:0] r_plus;
		w_plus = {1'b0, w} + {1'b0, margin};
		r_plus = {1'b0, ref_w} + {1'b0, margin};
		return (w_plus > {1'b0, ref_w}) && ({1'b0, w} < r_plus);
	endfunction

endpackage

[hw/rtl/ir_pulse_pair_decoder_unit.sv]
// ----------------------------------------------------------------------------
// ir_pulse_pair_decoder_unit: IR remote pulse-distance decoder
// Turns captured edge timestamps into decoded remote-control codes.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------------
//   in      | input     | in_valid/in_stall  | edge_time, new_frame
//   out     | output    | out_valid/out_stall| code_value, bit_count, ended_by_mismatch
//   cfg     | input     | wr_en              | wr_index, wr_data
//
// One beat is taken per clock cycle while in_stall is low. A result is registered
// once the beat that ends the frame has passed through the second stage.
// The first stage subtracts the previous edge time; the second scales the
// difference with one 16x8 multiplier, checks the pair windows and updates the code.
// Reset (arst_n low) restores the register defaults and leaves the decoder idle.
// The input is stalled only when the second stage holds a beat that ends a frame
// while an earlier result still waits on a stalled output.
//
module ir_pulse_pair_decoder_unit
	import irppd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [TIME_W-1:0]   edge_time,
	input  logic                new_frame,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [CODE_W-1:0]   code_value,
	output logic [COUNT_W-1:0]  bit_count,
	output logic                ended_by_mismatch,
	input  logic                wr_en,
	input  logic [INDEX_W-1:0]  wr_index,
	input  logic [DATA_W-1:0]   wr_data
);

	// Configuration registers.
	logic [TIME_W-1:0] zero_low_q, zero_high_q, one_low_q, one_high_q;
	logic [TOL_W-1:0]  tolerance_q;
	logic [TICK_W-1:0] us_tick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_low_q  <= ZERO_LOW_RST;
			zero_high_q <= ZERO_HIGH_RST;
			one_low_q   <= ONE_LOW_RST;
			one_high_q  <= ONE_HIGH_RST;
			tolerance_q <= TOLERANCE_RST;
			us_tick_q   <= US_TICK_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ZERO_LOW:  zero_low_q  <= wr_data;
				REG_ZERO_HIGH: zero_high_q <= wr_data;
				REG_ONE_LOW:   one_low_q   <= wr_data;
				REG_ONE_HIGH:  one_high_q  <= wr_data;
				REG_TOLERANCE: tolerance_q <= wr_data[TOL_W-1:0];
				REG_US_TICK:   us_tick_q   <= wr_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// The window margins depend on configuration only, so they are kept in
	// registers and refreshed every cycle. Configuration must change only while
	// the decoder is idle, unenforced here, so margins settle before the next beat.
	logic [TIME_W-1:0] m_zero_low_q, m_zero_high_q, m_one_low_q, m_one_high_q;

	always_ff @(posedge clk) begin
		m_zero_low_q  <= margin_of(zero_low_q, tolerance_q);
		m_zero_high_q <= margin_of(zero_high_q, tolerance_q);
		m_one_low_q   <= margin_of(one_low_q, tolerance_q);
		m_one_high_q  <= margin_of(one_high_q, tolerance_q);
	end

	// Stage 1: the edge-to-edge difference. The last edge time can follow every
	// accepted beat: while idle it is meaningless, since a new frame overwrites it.
	logic              valid_s1;
	logic              new_frame_s1;
	logic [TIME_W-1:0] diff_s1;
	logic [TIME_W-1:0] last_edge_q;
	logic              in_fire;
	logic              s1_move;
	logic              s1_fire;

	assign in_fire  = in_valid && !in_stall;
	assign in_stall = valid_s1 && !s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			last_edge_q <= '0;
		end else begin
			if (in_fire) begin
				last_edge_q <= edge_time;
			end
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			diff_s1      <= edge_time - last_edge_q;
			new_frame_s1 <= new_frame;
		end
	end

	// Stage 2 decode state.
	logic               frame_active_q;
	logic [HALF_W-1:0]  half_idx_q;
	logic [TIME_W-1:0]  held_low_q;
	logic [CODE_W-1:0]  code_q;
	logic [COUNT_W-1:0] bits_done_q;

	// Width in microseconds, saturated to 16 bits.
	logic [TIME_W+TICK_W-1:0] width_full;
	logic [TIME_W-1:0]        width;
	logic                     is_zero, is_one;
	logic                     data_pair;
	logic [COUNT_W-1:0]       bits_next;
	logic                     s1_emit;
	logic                     emit_mismatch;

	always_comb begin
		width_full = diff_s1 * us_tick_q;
		width = (|width_full[TIME_W+TICK_W-1:TIME_W]) ? {TIME_W{1'b1}}
			: width_full[TIME_W-1:0];
		is_zero = in_window(held_low_q, zero_low_q, m_zero_low_q)
			&& in_window(width, zero_high_q, m_zero_high_q);
		is_one = in_window(held_low_q, one_low_q, m_one_low_q)
			&& in_window(width, one_high_q, m_one_high_q);
		// A data pair completes on odd half-bit indexes from three upward.
		data_pair = !new_frame_s1 && frame_active_q
			&& (half_idx_q >= HALF_W'(2)) && half_idx_q[0];
		bits_next = bits_done_q + COUNT_W'(1);
		emit_mismatch = !(is_zero || is_one);
		s1_emit = data_pair && (emit_mismatch || (bits_next >= COUNT_W'(MAX_BITS)));
	end

	// Stage 2 holds back only when it would produce a result into a full,
	// stalled output register.
	assign s1_move = !(s1_emit && out_valid && out_stall);
	assign s1_fire = valid_s1 && s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_active_q <= 1'b0;
			half_idx_q     <= '0;
			held_low_q     <= '0;
			code_q         <= '0;
			bits_done_q    <= '0;
		end else if (s1_fire) begin
			if (new_frame_s1) begin
				frame_active_q <= 1'b1;
				half_idx_q     <= '0;
				held_low_q     <= '0;
				code_q         <= '0;
				bits_done_q    <= '0;
			end else if (frame_active_q) begin
				half_idx_q <= half_idx_q + HALF_W'(1);
				if (half_idx_q >= HALF_W'(2) && !half_idx_q[0]) begin
					held_low_q <= width;
				end else if (data_pair) begin
					if (is_zero || is_one) begin
						code_q      <= {code_q[CODE_W-2:0], !is_zero};
						bits_done_q <= bits_next;
					end
					if (s1_emit) begin
						frame_active_q <= 1'b0;
					end
				end
			end
		end
	end

	// Result register. The code and count shown on a bit-limit end include
	// the final bit; on a mismatch they are the bits gathered so far.
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && s1_emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && s1_emit) begin
			ended_by_mismatch <= emit_mismatch;
			if (emit_mismatch) begin
				code_value <= code_q;
				bit_count  <= bits_done_q;
			end else begin
				// The zero reference wins when both windows match.
				code_value <= {code_q[CODE_W-2:0], !is_zero};
				bit_count  <= bits_next;
			end
		end
	end

	assign out_valid = out_valid_q;

	// The bit counter never passes the frame limit.
	a_bits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		bits_done_q <= COUNT_W'(MAX_BITS))
		else $error("bit counter beyond frame limit");

	// A frame ended by the bit limit reports exactly the limit.
	a_limit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !ended_by_mismatch) |-> (bit_count == COUNT_W'(MAX_BITS)))
		else $error("bit-limit result with wrong count");

	// Emitting a result closes the frame.
	a_emit_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && s1_emit) |=> !frame_active_q)
		else $error("frame still active after result");

	// The input is only held back by a waiting second-stage beat.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without cause");

	// An overwrite of a waiting result never happens.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !(s1_fire && s1_emit))
		else $error("waiting result overwritten");

endmodule

[sim/ir_pulse_pair_decoder_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ir_pulse_pair_decoder_unit_test: self-checking bench for the IR decoder
// Sends edge timestamps grouped into frames of matching and broken pulse
// pairs under a series of register settings. A beat-level model predicts
// each decoded code, and every code leaving the block is checked against it.
// ----------------------------------------------------------------------------
module ir_pulse_pair_decoder_unit_test;
	import irppd_pkg::*;

	localparam int CLK_PERIOD = 8;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned ITEM_TARGET = 1100;
	// The pipe is given these cycles to drain after the last code has left.
	localparam int unsigned SETTLE_CYCLES = 5;
	localparam logic [INDEX_W-1:0] SPARE_INDEX_LO = 3'd6;
	localparam logic [INDEX_W-1:0] SPARE_INDEX_HI = 3'd7;

	typedef enum {PAIR_ZERO, PAIR_ONE, PAIR_JUNK} pair_kind_t;

	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [COUNT_W-1:0] count;
		logic               by_mismatch;
	} ir_code_t;

	// Every input of the block holds a known value from time zero.
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [TIME_W-1:0]  edge_time = '0;
	logic               new_frame = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [CODE_W-1:0]  code_value;
	logic [COUNT_W-1:0] bit_count;
	logic               ended_by_mismatch;
	logic               wr_en = 1'b0;
	logic [INDEX_W-1:0] wr_index = '0;
	logic [DATA_W-1:0]  wr_data = '0;

	// The model's copy of the registers, starting from the reset values.
	logic [TIME_W-1:0] p_zero_low = ZERO_LOW_RST;
	logic [TIME_W-1:0] p_zero_high = ZERO_HIGH_RST;
	logic [TIME_W-1:0] p_one_low = ONE_LOW_RST;
	logic [TIME_W-1:0] p_one_high = ONE_HIGH_RST;
	logic [TOL_W-1:0]  p_tol = TOLERANCE_RST;
	logic [TICK_W-1:0] p_tick = US_TICK_RST;

	// The model's copy of the decoder state; all of it starts cleared, as after reset.
	logic [TIME_W-1:0]  last_stamp = '0;
	logic [HALF_W-1:0]  half_idx = '0;
	logic [TIME_W-1:0]  held_low = '0;
	logic [CODE_W-1:0]  code_acc = '0;
	logic [COUNT_W-1:0] bits_got = '0;
	logic               frame_open = 1'b0;

	ir_code_t pending_codes[$];

	logic [TIME_W-1:0] timer_now = '0;
	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;
	int unsigned live_items = 0;
	int unsigned codes_seen = 0;
	int unsigned limit_ends = 0;
	int unsigned settings_applied = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned hold_left = 0;

	ir_pulse_pair_decoder_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.edge_time(edge_time),
		.new_frame(new_frame),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.code_value(code_value),
		.bit_count(bit_count),
		.ended_by_mismatch(ended_by_mismatch),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d codes still due", cycle_count,
				pending_codes.size());
			$display("status: fail");
			$finish;
		end
	end

	// A width matches a reference only strictly inside the margin on both sides,
	// so a zero tolerance or a zero reference never matches.
	function automatic bit fits_window(input logic [TIME_W-1:0] w,
		input logic [TIME_W-1:0] ref_us);
		int unsigned slack;
		slack = (int'(ref_us) * int'(p_tol)) >> 8;
		return (w + slack > ref_us) && (w < ref_us + slack);
	endfunction

	// Model of one accepted beat. A finished frame pushes its expected code.
	task automatic decode_edge(input logic [TIME_W-1:0] t, input logic nf);
		logic [TIME_W-1:0] span;
		int unsigned scaled;
		logic [TIME_W-1:0] width_us;
		bit fits_zero;
		bit fits_one;
		if (nf) begin
			last_stamp = t;
			half_idx = '0;
			held_low = '0;
			code_acc = '0;
			bits_got = '0;
			frame_open = 1'b1;
			live_items++;
			return;
		end
		// Edges outside a frame are dropped by the block.
		if (!frame_open)
			return;
		live_items++;
		// The 16-bit difference wraps with the timer; the scaled width saturates.
		span = t - last_stamp;
		last_stamp = t;
		scaled = int'(span) * int'(p_tick);
		width_us = (scaled > 32'hFFFF) ? 16'hFFFF : scaled[TIME_W-1:0];
		// The first low/high pair is the start pulse.
		if (half_idx < 2) begin
			half_idx++;
			return;
		end
		if (!half_idx[0]) begin
			held_low = width_us;
			half_idx++;
			return;
		end
		half_idx++;
		fits_zero = fits_window(held_low, p_zero_low) && fits_window(width_us, p_zero_high);
		fits_one = fits_window(held_low, p_one_low) && fits_window(width_us, p_one_high);
		if (!fits_zero && !fits_one) begin
			pending_codes.push_back('{code_acc, bits_got, 1'b1});
			frame_open = 1'b0;
			return;
		end
		// The zero reference takes priority when both windows match.
		code_acc = {code_acc[CODE_W-2:0], !fits_zero};
		bits_got++;
		if (bits_got >= MAX_BITS) begin
			pending_codes.push_back('{code_acc, bits_got, 1'b0});
			frame_open = 1'b0;
		end
	endtask

	// Sends one beat. Called at a rising edge; returns at the edge that took it.
	// The valid is either lowered for a gap or left high, never both in one step.
	task automatic send_edge(input logic [TIME_W-1:0] t, input logic nf);
		int unsigned gap;
		bit go;
		gap = gaps_on ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		edge_time <= t;
		new_frame <= nf;
		// The stall is read at the falling edge, where it has settled.
		do begin
			@(negedge clk);
			go = (in_stall === 1'b0);
			@(posedge clk);
		end while (!go);
		decode_edge(t, nf);
	endtask

	task automatic edge_after(input logic [TIME_W-1:0] ticks, input logic nf);
		timer_now = timer_now + ticks;
		send_edge(timer_now, nf);
	endtask

	// Timer ticks for a width drawn around a reference, reaching one microsecond
	// past the margin on either side so that the window borders get hit.
	function automatic logic [TIME_W-1:0] ticks_near(input logic [TIME_W-1:0] ref_us);
		int slack;
		int w;
		slack = (int'(ref_us) * int'(p_tol)) >>> 8;
		w = int'(ref_us) - slack - 1 + int'($urandom_range(0, 2 * slack + 2));
		if (w < 0)
			w = 0;
		if (w > 65535)
			w = 65535;
		if (p_tick == 0)
			return 16'($urandom_range(0, 2000));
		w = (w + int'(p_tick) / 2) / int'(p_tick);
		return 16'(w);
	endfunction

	task automatic send_pair(input pair_kind_t kind);
		logic [TIME_W-1:0] lo_ticks;
		logic [TIME_W-1:0] hi_ticks;
		case (kind)
			PAIR_ZERO: begin
				lo_ticks = ticks_near(p_zero_low);
				hi_ticks = ticks_near(p_zero_high);
			end
			PAIR_ONE: begin
				lo_ticks = ticks_near(p_one_low);
				hi_ticks = ticks_near(p_one_high);
			end
			default: begin
				lo_ticks = 16'($urandom_range(0, $urandom_range(0, 1) ? 65535 : 400));
				hi_ticks = 16'($urandom_range(0, $urandom_range(0, 1) ? 65535 : 400));
			end
		endcase
		edge_after(lo_ticks, 1'b0);
		edge_after(hi_ticks, 1'b0);
	endtask

	// A frame: opening edge, start pulse of any widths, then data pairs.
	task automatic send_frame(input int unsigned nbits, input bit close_with_junk);
		edge_after(16'($urandom), 1'b1);
		edge_after(16'($urandom_range(0, 20000)), 1'b0);
		edge_after(16'($urandom_range(0, 20000)), 1'b0);
		repeat (nbits)
			send_pair($urandom_range(0, 1) ? PAIR_ONE : PAIR_ZERO);
		if (close_with_junk)
			send_pair(PAIR_JUNK);
	endtask

	// Mostly well-formed frames, with noise edges, frames cut short by a new
	// frame, and frames that run past the bit limit into ignored edges.
	task automatic run_frames(input int unsigned budget);
		int unsigned stop_at;
		stop_at = live_items + budget;
		while (live_items < stop_at) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 7))
				0: repeat ($urandom_range(1, 4))
					edge_after(16'($urandom), $urandom_range(0, 5) == 0);
				1: send_frame($urandom_range(0, 31), 1'b0);
				2, 3: send_frame(MAX_BITS + $urandom_range(0, 2), 1'b0);
				default: send_frame($urandom_range(0, 24), 1'b1);
			endcase
		end
	endtask

	// Waits until the block is idle: no code due and the pipe drained.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_codes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		case (idx)
			REG_ZERO_LOW:  p_zero_low = val;
			REG_ZERO_HIGH: p_zero_high = val;
			REG_ONE_LOW:   p_one_low = val;
			REG_ONE_HIGH:  p_one_high = val;
			REG_TOLERANCE: p_tol = val[TOL_W-1:0];
			REG_US_TICK:   p_tick = val[TICK_W-1:0];
			default: ;
		endcase
	endtask

	// Writes all six registers while idle, then one index past the list,
	// which the block must ignore.
	task automatic apply_settings(input logic [DATA_W-1:0] zero_lo,
		input logic [DATA_W-1:0] zero_hi, input logic [DATA_W-1:0] one_lo,
		input logic [DATA_W-1:0] one_hi, input logic [DATA_W-1:0] tol,
		input logic [DATA_W-1:0] tick);
		settle();
		write_reg(REG_ZERO_LOW, zero_lo);
		write_reg(REG_ZERO_HIGH, zero_hi);
		write_reg(REG_ONE_LOW, one_lo);
		write_reg(REG_ONE_HIGH, one_hi);
		write_reg(REG_TOLERANCE, tol);
		write_reg(REG_US_TICK, tick);
		write_reg($urandom_range(0, 1) ? SPARE_INDEX_LO : SPARE_INDEX_HI, 16'($urandom));
		wr_en <= 1'b0;
		settings_applied++;
	endtask

	task automatic log_error(input string what, input ir_code_t want, input ir_code_t got);
		error_count++;
		if (error_count <= 10)
			$display("error: %s: expected code %h bits %0d mismatch %0b,",
				what, want.code, want.count, want.by_mismatch,
				" got code %h bits %0d mismatch %0b",
				got.code, got.count, got.by_mismatch);
	endtask

	// Result side: samples at the falling edge, counts the beat at the rising
	// edge, then draws how long to stall before the next code.
	initial begin : code_checker
		ir_code_t got;
		ir_code_t want;
		bit took;
		forever begin
			@(negedge clk);
			took = (arst_n === 1'b1) && (out_valid === 1'b1) && (out_stall === 1'b0);
			got = '{code_value, bit_count, ended_by_mismatch};
			@(posedge clk);
			if (took) begin
				codes_seen++;
				if (pending_codes.size() == 0) begin
					log_error("code with none due", '0, got);
				end else begin
					want = pending_codes.pop_front();
					if (!want.by_mismatch)
						limit_ends++;
					if (got.code !== want.code || got.count !== want.count
						|| got.by_mismatch !== want.by_mismatch)
						log_error("code differs", want, got);
				end
				hold_left = stalls_on ? $urandom_range(0, 3) : 0;
			end else if (hold_left != 0) begin
				hold_left--;
			end
			out_stall <= (hold_left != 0);
		end
	end

	// Edges with no frame open are dropped, at both ends of the timer range.
	task automatic test_idle_edges();
		send_edge(16'h0000, 1'b0);
		send_edge(16'hFFFF, 1'b0);
	endtask

	// Default settings count one tick per microsecond: a zero, a one, then a
	// pair far off both references closes the frame with code 01.
	task automatic test_short_frame();
		timer_now = 16'd100;
		edge_after(16'd7, 1'b1);
		edge_after(16'd9000, 1'b0);
		edge_after(16'd4500, 1'b0);
		edge_after(16'd560, 1'b0);
		edge_after(16'd560, 1'b0);
		edge_after(16'd560, 1'b0);
		edge_after(16'd1690, 1'b0);
		edge_after(16'd3000, 1'b0);
		edge_after(16'd3000, 1'b0);
	endtask

	// A frame straddling the timer wrap is dropped by a second opening edge;
	// the new frame takes a one and ends on the widest and the narrowest widths.
	task automatic test_frame_restart();
		timer_now = 16'hFFF0;
		edge_after(16'd0, 1'b1);
		edge_after(16'd9000, 1'b0);
		edge_after(16'd4500, 1'b0);
		edge_after(16'd560, 1'b0);
		edge_after(16'd560, 1'b0);
		edge_after(16'd100, 1'b1);
		edge_after(16'd9000, 1'b0);
		edge_after(16'd4500, 1'b0);
		edge_after(16'd560, 1'b0);
		edge_after(16'd1690, 1'b0);
		edge_after(16'hFFFF, 1'b0);
		edge_after(16'h0000, 1'b0);
	endtask

	task automatic test_default_config();
		run_frames(200);
	endtask

	// Ten microseconds per tick; the upper data byte must be dropped.
	task automatic test_coarse_tick();
		apply_settings(16'd560, 16'd560, 16'd560, 16'd1690, 16'h5A50, 16'hA50A);
		run_frames(150);
	endtask

	// Widest references, widest margin and the largest tick factor, so long
	// gaps saturate; a zero reference never matches.
	task automatic test_saturation_extremes();
		apply_settings(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h00FF, 16'h00FF);
		run_frames(120);
	endtask

	// With no tolerance every frame ends at its first data pair.
	task automatic test_zero_tolerance();
		apply_settings(16'd560, 16'd560, 16'd560, 16'd1690, 16'hFF00, 16'h0001);
		run_frames(60);
	endtask

	// Only the upper byte is set, so the tick factor is zero and every
	// width scales to zero.
	task automatic test_zero_tick();
		apply_settings(16'd0, 16'd560, 16'd560, 16'd1690, 16'd51, 16'h0100);
		run_frames(60);
	endtask

	// Random references, margins and tick factors until enough edges have
	// gone through.
	task automatic test_random_configs();
		do begin
			if ($urandom_range(0, 4) == 0)
				apply_settings(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), {8'($urandom), 8'($urandom_range(1, 255))});
			else
				apply_settings(16'($urandom_range(100, 3000)), 16'($urandom_range(100, 3000)),
					16'($urandom_range(100, 20000)), 16'($urandom_range(100, 20000)),
					{8'($urandom), 8'($urandom_range(8, 255))},
					{8'($urandom), 8'($urandom_range(0, 1) ? $urandom_range(1, 8)
						: $urandom_range(1, 255))});
			run_frames(130);
			settle();
		end while (live_items < ITEM_TARGET);
	endtask

	initial begin : run_tests
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_edges();
		test_short_frame();
		test_frame_restart();
		test_default_config();
		test_coarse_tick();
		test_saturation_extremes();
		test_zero_tolerance();
		test_zero_tick();
		test_random_configs();

		settle();
		$display("covered %0d decoded edges and %0d codes, %0d of them closed by the bit limit",
			live_items, codes_seen, limit_ends);
		$display("ran under %0d register settings, %0d errors", settings_applied + 1,
			error_count);
		if (error_count == 0 && pending_codes.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/irppd_pkg.sv
hw/rtl/ir_pulse_pair_decoder_unit.sv
sim/ir_pulse_pair_decoder_unit_test.sv
